// ----- src/same_frame_pair_matcher_assert.svh -----
// Assertion macros used by the matcher top level.
`ifndef SAME_FRAME_PAIR_MATCHER_ASSERT_SVH
`define SAME_FRAME_PAIR_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define SFPM_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define SFPM_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`endif

// ----- src/smpm_pkg.sv -----
`default_nettype none
package smpm_pkg;

    localparam int POS_W = 24;
    localparam int INV_W = 41;
    localparam int CNT_W = 32;
    localparam int IN_DATA_W = 120;
    localparam int OUT_DATA_W = 248;
    localparam int CFG_IDX_W = 3;

    // fixed-point one
    localparam logic [INV_W-1:0] ONE_FX = 41'h100_0000_0000;
    localparam logic [INV_W-1:0] INV_RESET = 41'd1717987;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X  = 3'd0,
        REG_OFFSET_Y  = 3'd1,
        REG_OFFSET_Z  = 3'd2,
        REG_INV_X     = 3'd3,
        REG_INV_Y     = 3'd4,
        REG_INV_Z     = 3'd5,
        REG_USE_Z     = 3'd6,
        REG_PAIR_MODE = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FLUSH
    } ctrl_state_t;

    // one stored localization
    typedef struct packed {
        logic [POS_W-1:0] amp;
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } entry_t;

    // one result, packed as on m_tdata (lowest field last here)
    typedef struct packed {
        logic [CNT_W-1:0] pair_count;
        logic [POS_W-1:0] pair_frame;
        logic [POS_W-1:0] long_amp;
        logic [POS_W-1:0] long_z;
        logic [POS_W-1:0] long_y;
        logic [POS_W-1:0] long_x;
        logic [POS_W-1:0] short_amp;
        logic [POS_W-1:0] short_z;
        logic [POS_W-1:0] short_y;
        logic [POS_W-1:0] short_x;
    } result_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic flush_ok;
        logic pend_valid;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- src/smpm_ctrl.sv -----
`default_nettype none
module smpm_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire smpm_pkg::dp_status_t   status,
    output smpm_pkg::dp_cmd_t           cmd,
    output smpm_pkg::ctrl_state_t       state
);
    import smpm_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.issue_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (status.flush_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule
`default_nettype wire

// ----- src/smpm_dp.sv -----
`default_nettype none
module smpm_dp #(
    parameter int MAX_PER_FRAME = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [smpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smpm_pkg::INV_W-1:0]        cfg_wdata,
    input  wire logic [smpm_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire smpm_pkg::dp_cmd_t                 cmd,
    output smpm_pkg::dp_status_t                   status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [smpm_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tlast
);
    import smpm_pkg::*;

    localparam int CW = $clog2(MAX_PER_FRAME + 1);
    localparam int AW = $clog2(MAX_PER_FRAME);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PER_FRAME);

    // configuration registers
    logic signed [POS_W-1:0] off_reg [3];
    logic [INV_W-1:0]        inv_reg [3];
    logic                    use_z_reg;
    logic [1:0]              mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                off_reg[k] <= '0;
                inv_reg[k] <= INV_RESET;
            end
            use_z_reg <= 1'b0;
            mode_reg  <= 2'd0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_OFFSET_X:  off_reg[0] <= cfg_wdata[POS_W-1:0];
                REG_OFFSET_Y:  off_reg[1] <= cfg_wdata[POS_W-1:0];
                REG_OFFSET_Z:  off_reg[2] <= cfg_wdata[POS_W-1:0];
                REG_INV_X:     inv_reg[0] <= cfg_wdata;
                REG_INV_Y:     inv_reg[1] <= cfg_wdata;
                REG_INV_Z:     inv_reg[2] <= cfg_wdata;
                REG_USE_Z:     use_z_reg  <= cfg_wdata[0];
                REG_PAIR_MODE: mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [POS_W-1:0] in_frame;
    entry_t           in_entry;
    assign in_frame     = s_tdata[23:0];
    assign in_entry.x   = s_tdata[47:24];
    assign in_entry.y   = s_tdata[71:48];
    assign in_entry.z   = use_z_reg ? s_tdata[95:72] : '0;
    assign in_entry.amp = s_tdata[119:96];

    // frame bookkeeping and issue counter
    logic [POS_W-1:0] held_frame_reg;
    logic [CW-1:0]    held_cnt_reg;
    logic [CW-1:0]    cmp_n_reg;
    logic [CW-1:0]    rd_idx_reg;
    logic [CW-1:0]    eff_cnt;
    logic             room;
    logic             issuing;
    logic             adv;

    assign eff_cnt = (in_frame == held_frame_reg) ? held_cnt_reg : '0;
    assign room    = (eff_cnt < MAX_C);
    assign issuing = cmd.issue && (rd_idx_reg != cmp_n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_frame_reg <= '0;
            held_cnt_reg   <= '0;
            cmp_n_reg      <= '0;
            rd_idx_reg     <= '0;
        end else if (cmd.accept) begin
            held_frame_reg <= in_frame;
            held_cnt_reg   <= eff_cnt + {{(CW-1){1'b0}}, room};
            cmp_n_reg      <= eff_cnt;
            rd_idx_reg     <= '0;
        end else if (issuing && adv) begin
            rd_idx_reg <= rd_idx_reg + CW'(1);
        end
    end

    // entry store: written on acceptance while there is room, read one entry per cycle while the pipeline advances
    entry_t           mem [MAX_PER_FRAME];
    entry_t           b_reg;
    logic [POS_W-1:0] b_frame_reg;
    entry_t           rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            b_reg       <= in_entry;
            b_frame_reg <= in_frame;
            if (room) begin
                mem[eff_cnt[AW-1:0]] <= in_entry;
            end
        end
        if (issuing && adv) begin
            rd_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // pipeline valid bits
    logic v0_reg, v1_reg, v2_reg, v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= issuing;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: offset differences in both directions, magnitude limit
    entry_t      a0;
    logic [23:0] a_pos [3];
    logic [23:0] b_pos [3];
    logic signed [25:0] diff [2][3];
    logic [25:0] mag_full [2][3];

    assign a0 = '{amp: rd_reg.amp, z: (use_z_reg ? rd_reg.z : '0), y: rd_reg.y, x: rd_reg.x};
    assign a_pos[0] = a0.x;
    assign a_pos[1] = a0.y;
    assign a_pos[2] = a0.z;
    assign b_pos[0] = b_reg.x;
    assign b_pos[1] = b_reg.y;
    assign b_pos[2] = b_reg.z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[0][k] = $signed({{2{a_pos[k][23]}}, a_pos[k]})
                       - $signed({{2{off_reg[k][23]}}, off_reg[k]})
                       - $signed({{2{b_pos[k][23]}}, b_pos[k]});
            diff[1][k] = $signed({{2{b_pos[k][23]}}, b_pos[k]})
                       - $signed({{2{off_reg[k][23]}}, off_reg[k]})
                       - $signed({{2{a_pos[k][23]}}, a_pos[k]});
            for (int d = 0; d < 2; d++) begin
                mag_full[d][k] = diff[d][k][25] ? 26'(-diff[d][k]) : 26'(diff[d][k]);
            end
        end
    end

    logic [20:0] mag1_reg [2][3];
    logic        ovf1_reg [2][3];
    entry_t      e1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg <= a0;
            for (int d = 0; d < 2; d++) begin
                for (int k = 0; k < 3; k++) begin
                    mag1_reg[d][k] <= mag_full[d][k][20:0];
                    // square beyond one already, unless the axis weight is zero
                    ovf1_reg[d][k] <= (mag_full[d][k] > 26'd1048576) && (inv_reg[k] != '0);
                end
            end
        end
    end

    // stage 2: magnitude times inverse tolerance
    logic [61:0] p1 [2][3];
    always_comb begin
        for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < 3; k++) begin
                p1[d][k] = {41'd0, mag1_reg[d][k]} * {21'd0, inv_reg[k]};
            end
        end
    end

    logic [40:0] p2_reg   [2][3];
    logic [20:0] mag2_reg [2][3];
    logic        ovf2_reg [2][3];
    entry_t      e2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e2_reg <= e1_reg;
            for (int d = 0; d < 2; d++) begin
                for (int k = 0; k < 3; k++) begin
                    p2_reg[d][k]   <= p1[d][k][40:0];
                    mag2_reg[d][k] <= mag1_reg[d][k];
                    ovf2_reg[d][k] <= ovf1_reg[d][k] || (p1[d][k] > {21'd0, ONE_FX});
                end
            end
        end
    end

    // stage 3: times magnitude again gives the weighted square
    logic [61:0] p3 [2][3];
    always_comb begin
        for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < 3; k++) begin
                p3[d][k] = {21'd0, p2_reg[d][k]} * {41'd0, mag2_reg[d][k]};
            end
        end
    end

    logic [40:0] t3_reg   [2][3];
    logic        ovf3_reg [2][3];
    entry_t      e3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e3_reg <= e2_reg;
            for (int d = 0; d < 2; d++) begin
                for (int k = 0; k < 3; k++) begin
                    t3_reg[d][k]   <= p3[d][k][40:0];
                    ovf3_reg[d][k] <= ovf2_reg[d][k] || (p3[d][k] > {21'd0, ONE_FX});
                end
            end
        end
    end

    // match decision and partner choice
    logic [42:0] sum   [2];
    logic        ok    [2];
    logic        match;
    logic [23:0] ca, cb;
    logic        a_smaller, short_new;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_inc;
    result_t     new_res;

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            sum[d] = {2'd0, t3_reg[d][0]} + {2'd0, t3_reg[d][1]}
                   + (use_z_reg ? {2'd0, t3_reg[d][2]} : 43'd0);
            ok[d]  = !(ovf3_reg[d][0] || ovf3_reg[d][1] || (use_z_reg && ovf3_reg[d][2]))
                   && (sum[d] <= {2'd0, ONE_FX});
        end
    end

    assign match     = v3_reg && (ok[0] || ok[1]);
    assign ca        = mode_reg[0] ? e3_reg.y : e3_reg.x;
    assign cb        = mode_reg[0] ? b_reg.y : b_reg.x;
    assign a_smaller = $signed(ca) < $signed(cb);
    assign short_new = mode_reg[1] ? a_smaller : !a_smaller;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + CNT_W'(1);

    always_comb begin
        new_res.pair_count = total_inc;
        new_res.pair_frame = b_frame_reg;
        if (short_new) begin
            new_res.short_x   = b_reg.x;
            new_res.short_y   = b_reg.y;
            new_res.short_z   = b_reg.z;
            new_res.short_amp = b_reg.amp;
            new_res.long_x    = e3_reg.x;
            new_res.long_y    = e3_reg.y;
            new_res.long_z    = e3_reg.z;
            new_res.long_amp  = e3_reg.amp;
        end else begin
            new_res.short_x   = e3_reg.x;
            new_res.short_y   = e3_reg.y;
            new_res.short_z   = e3_reg.z;
            new_res.short_amp = e3_reg.amp;
            new_res.long_x    = b_reg.x;
            new_res.long_y    = b_reg.y;
            new_res.long_z    = b_reg.z;
            new_res.long_amp  = b_reg.amp;
        end
    end

    // pending result (held back until its last flag is known) and output register
    result_t pend_reg, out_reg;
    logic    pend_valid_reg, out_valid_reg, out_last_reg;
    logic    out_free, push_mid, push_flush;

    assign out_free   = !out_valid_reg || m_tready;
    assign adv        = !(match && pend_valid_reg && !out_free);
    assign push_mid   = adv && match && pend_valid_reg;
    assign push_flush = cmd.flush && pend_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            total_reg      <= '0;
        end else begin
            if (adv && match) begin
                pend_valid_reg <= 1'b1;
                total_reg      <= total_inc;
            end else if (push_flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_mid || push_flush) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && match) begin
            pend_reg <= new_res;
        end
        if (push_mid || push_flush) begin
            out_reg      <= pend_reg;
            out_last_reg <= push_flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    assign status.issue_done = (rd_idx_reg == cmp_n_reg);
    assign status.pipe_busy  = v0_reg || v1_reg || v2_reg || v3_reg;
    assign status.flush_ok   = !pend_valid_reg || out_free;
    assign status.pend_valid = pend_valid_reg;

endmodule
`default_nettype wire

// ----- src/same_frame_pair_matcher.sv -----
`default_nettype none
// Same-frame pair matcher.
// s_ channel: one localization per transaction, sorted by frame number.
// m_ channel: one matched pair per transaction; m_tlast marks the final
// pair caused by one localization. A localization with no match gives none.
// cfg_ port: offsets, inverse tolerances, use_z and pairing mode; write only
// while the block is idle.
// Each localization is accepted, then each stored entry of its frame (up to
// MAX_PER_FRAME) is read through the single read port of the entry store
// and passes the compare pipeline, which then drains and releases the last
// pair. When no entry of its frame is stored, nothing is read.
// The first pair passes the read register, the compare stage registers and
// the pending register before it reaches the output register.
// Reset empties the store, zeroes the frame and pair counter and loads the
// register defaults; no clearing pass is needed.
// When the receiver stalls, one pair waits in the output register and one
// more in a pending register; further matches freeze the pipeline.
// A new localization is taken while the last pair still waits on m_.
module same_frame_pair_matcher #(
    parameter int MAX_PER_FRAME = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [smpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smpm_pkg::INV_W-1:0]        cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // frame_number, pos_x, pos_y, pos_z, amplitude
    input  wire logic [smpm_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // short_x, short_y, short_z, short_amplitude, long_x, long_y, long_z,
    // long_amplitude, pair_frame, pair_count
    output logic [smpm_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tlast
);
    import smpm_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    ctrl_state_t state;

    smpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    smpm_dp #(
        .MAX_PER_FRAME (MAX_PER_FRAME)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`include "same_frame_pair_matcher_assert.svh"

    // one localization at a time
    `SFPM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // nothing held back or in flight once idle
    `SFPM_ASSERT_IMPLY(a_idle_no_pend, aclk, aresetn, state == ST_IDLE, !status.pend_valid)
    `SFPM_ASSERT_IMPLY(a_idle_no_pipe, aclk, aresetn, state == ST_IDLE, !status.pipe_busy)

endmodule
`default_nettype wire

// ----- tb/same_frame_pair_matcher_tb.sv -----
`default_nettype none
module same_frame_pair_matcher_tb;
    import smpm_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 48;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    reg_idx_t              cfg_index = REG_OFFSET_X;
    logic [INV_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // frame_number, pos_x, pos_y, pos_z, amplitude
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // short_x, short_y, short_z, short_amplitude, long_x, long_y, long_z,
    // long_amplitude, pair_frame, pair_count
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    same_frame_pair_matcher #(.MAX_PER_FRAME(STORE_DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    typedef struct {
        result_t pair;
        logic    last;
    } pair_expect_t;

    pair_expect_t expected_pairs[$];

    // shadow of the matcher's registers and frame store
    logic signed [23:0] off_x, off_y, off_z;
    logic [INV_W-1:0]   inv_x, inv_y, inv_z;
    logic               use_z_r;
    logic [1:0]         mode_r;
    logic signed [23:0] held_x [STORE_DEPTH];
    logic signed [23:0] held_y [STORE_DEPTH];
    logic signed [23:0] held_z [STORE_DEPTH];
    logic [23:0]        held_amp [STORE_DEPTH];
    int                 held_n;
    logic [23:0]        held_fr;
    logic [31:0]        pairs_total;

    int errors = 0;
    int locs_sent = 0;
    int pairs_seen = 0;
    int burst_left = 0;
    int gap_max = 6;
    int stall_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // squared difference times inverse tolerance, saturating at 64 bits
    function automatic logic [63:0] weighted_sq(logic signed [26:0] d, logic [INV_W-1:0] inv);
        logic [26:0]  mag;
        logic [127:0] p;
        mag = (d < 0) ? -d : d;
        p = 128'(mag) * 128'(mag) * 128'(inv);
        return (p > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // ellipsoid distance of a from b after removing the channel offset
    function automatic logic [63:0] ellipsoid_dist(logic signed [26:0] ax, ay, az,
                                                   logic signed [26:0] bx, by, bz);
        logic [63:0] s;
        logic signed [26:0] ox, oy, oz;
        ox = off_x;
        oy = off_y;
        oz = off_z;
        s = weighted_sq(ax - ox - bx, inv_x);
        s = sat_sum(s, weighted_sq(ay - oy - by, inv_y));
        if (use_z_r)
            s = sat_sum(s, weighted_sq(az - oz - bz, inv_z));
        return s;
    endfunction

    // expected pairs for one accepted localization, then store it
    task automatic predict_pairs(logic [23:0] fr, logic signed [23:0] bx, by, bz_in,
                                 logic [23:0] bamp);
        logic signed [23:0] bz, ax, ay, az, ca, cb;
        logic               short_new;
        pair_expect_t       e;
        pair_expect_t       found[$];
        bz = use_z_r ? bz_in : 24'sd0;
        if (fr != held_fr)
            held_n = 0;
        held_fr = fr;
        for (int i = 0; i < held_n; i++) begin
            ax = held_x[i];
            ay = held_y[i];
            az = use_z_r ? held_z[i] : 24'sd0;
            if (ellipsoid_dist(ax, ay, az, bx, by, bz) <= 64'(ONE_FX) ||
                ellipsoid_dist(bx, by, bz, ax, ay, az) <= 64'(ONE_FX)) begin
                ca = mode_r[0] ? ay : ax;
                cb = mode_r[0] ? by : bx;
                short_new = mode_r[1] ? (ca < cb) : !(ca < cb);
                if (short_new) begin
                    e.pair.short_x = bx; e.pair.short_y = by;
                    e.pair.short_z = bz; e.pair.short_amp = bamp;
                    e.pair.long_x = ax; e.pair.long_y = ay;
                    e.pair.long_z = az; e.pair.long_amp = held_amp[i];
                end else begin
                    e.pair.short_x = ax; e.pair.short_y = ay;
                    e.pair.short_z = az; e.pair.short_amp = held_amp[i];
                    e.pair.long_x = bx; e.pair.long_y = by;
                    e.pair.long_z = bz; e.pair.long_amp = bamp;
                end
                if (pairs_total != 32'hFFFF_FFFF)
                    pairs_total++;
                e.pair.pair_frame = fr;
                e.pair.pair_count = pairs_total;
                e.last = 1'b0;
                found.insert(found.size(), e);
            end
        end
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[k])
            expected_pairs.insert(expected_pairs.size(), found[k]);
        if (held_n < STORE_DEPTH) begin
            held_x[held_n] = bx;
            held_y[held_n] = by;
            held_z[held_n] = bz;
            held_amp[held_n] = bamp;
            held_n++;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // result checker
    always @(posedge aclk) begin : check_pairs
        result_t      got;
        pair_expect_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            pairs_seen++;
            if (expected_pairs.size() == 0) begin
                report_mismatch("pair with none expected", got.pair_count, 32'd0);
            end else begin
                e = expected_pairs.pop_front();
                compare_field("short_x", got.short_x, e.pair.short_x);
                compare_field("short_y", got.short_y, e.pair.short_y);
                compare_field("short_z", got.short_z, e.pair.short_z);
                compare_field("short_amplitude", got.short_amp, e.pair.short_amp);
                compare_field("long_x", got.long_x, e.pair.long_x);
                compare_field("long_y", got.long_y, e.pair.long_y);
                compare_field("long_z", got.long_z, e.pair.long_z);
                compare_field("long_amplitude", got.long_amp, e.pair.long_amp);
                compare_field("pair_frame", got.pair_frame, e.pair.pair_frame);
                compare_field("pair_count", got.pair_count, e.pair.pair_count);
                compare_field("last", m_tlast, e.last);
            end
        end
    end

    // receiver stalls in random runs; stall_pct of zero gives a clean stretch
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout with %0d pairs outstanding", expected_pairs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(reg_idx_t idx, logic [INV_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_OFFSET_X:  off_x = value[23:0];
            REG_OFFSET_Y:  off_y = value[23:0];
            REG_OFFSET_Z:  off_z = value[23:0];
            REG_INV_X:     inv_x = value;
            REG_INV_Y:     inv_y = value;
            REG_INV_Z:     inv_z = value;
            REG_USE_Z:     use_z_r = value[0];
            REG_PAIR_MODE: mode_r = value[1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all_regs(logic signed [23:0] ox, oy, oz,
                                logic [INV_W-1:0] ix, iy, iz, logic uz, logic [1:0] md);
        cfg_write(REG_OFFSET_X, INV_W'(ox));
        cfg_write(REG_OFFSET_Y, INV_W'(oy));
        cfg_write(REG_OFFSET_Z, INV_W'(oz));
        cfg_write(REG_INV_X, ix);
        cfg_write(REG_INV_Y, iy);
        cfg_write(REG_INV_Z, iz);
        cfg_write(REG_USE_Z, INV_W'(uz));
        cfg_write(REG_PAIR_MODE, INV_W'(md));
    endtask

    // sender pauses until every expected pair is out and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one localization transaction, with bursts and random gaps
    task automatic send_loc(logic [23:0] fr, logic signed [23:0] x, y, z, logic [23:0] amp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {amp, z, y, x, fr};
        do @(posedge aclk); while (!s_tready);
        predict_pairs(fr, x, y, z, amp);
        locs_sent++;
    endtask

    function automatic logic signed [23:0] jitter(logic signed [23:0] v, int spread);
        return v + 24'($urandom_range(0, 2 * spread)) - 24'(spread);
    endfunction

    // coordinate of the other channel: base shifted by the offset, if it fits
    function automatic logic signed [23:0] other_channel(logic signed [23:0] b,
                                                          logic signed [23:0] o);
        longint t;
        t = longint'(b) + longint'(o);
        if (t < -8388608 || t > 8388607)
            t = longint'(b) - longint'(o);
        return t[23:0];
    endfunction

    // frames of clustered localizations with some noise
    task automatic run_frames(int n_locs, int spread, int max_per);
        logic [23:0]        fr;
        logic signed [23:0] bx, by, bz, x, y, z;
        int                 k, r;
        fr = held_fr;
        while (n_locs > 0) begin
            r = $urandom_range(0, 14);
            if (r == 0)
                fr = 24'($urandom);
            else if (r == 1)
                fr = fr - 24'($urandom_range(1, 3));
            else
                fr = fr + 24'($urandom_range(1, 3));
            bx = 24'($signed($urandom_range(0, 2097152)) - 1048576);
            by = 24'($signed($urandom_range(0, 2097152)) - 1048576);
            bz = 24'($signed($urandom_range(0, 2097152)) - 1048576);
            k = $urandom_range(1, max_per);
            for (int i = 0; i < k; i++) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    send_loc(fr, 24'($urandom), 24'($urandom), 24'($urandom),
                             24'($urandom));
                end else begin
                    if (r < 5) begin
                        x = bx; y = by; z = bz;
                    end else begin
                        x = other_channel(bx, off_x);
                        y = other_channel(by, off_y);
                        z = other_channel(bz, off_z);
                    end
                    send_loc(fr, jitter(x, spread), jitter(y, spread), jitter(z, spread),
                             24'($urandom));
                end
            end
            n_locs -= k;
        end
    endtask

    // edges of the fields, frame changes both ways, pairing under each mode
    task automatic test_directed();
        stall_pct = 0;
        gap_max = 0;
        send_loc(24'd0, 24'sd0, 24'sd0, 24'sd0, 24'd0);
        send_loc(24'd0, 24'sd0, 24'sd0, 24'sd0, 24'hFFFFFF);
        send_loc(24'd0, 24'sd799, 24'sd0, -24'sd5, 24'd7);
        send_loc(24'd0, -24'sd8388608, 24'sd8388607, 24'sd8388607, 24'd1);
        send_loc(24'hFFFFFF, 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'h800000);
        send_loc(24'hFFFFFF, 24'sd8388607, -24'sd8388608, 24'sd1, 24'h7FFFFF);
        send_loc(24'd5, 24'sd10, 24'sd10, 24'sd0, 24'd3);
        send_loc(24'd5, 24'sd811, 24'sd10, 24'sd0, 24'd4);
        for (int m = 0; m < 4; m++) begin
            wait_idle();
            cfg_write(REG_PAIR_MODE, INV_W'(m));
            send_loc(24'(10 + m), 24'sd100, 24'sd300, 24'sd0, 24'd11);
            send_loc(24'(10 + m), 24'sd200, 24'sd100, 24'sd0, 24'd22);
            send_loc(24'(10 + m), 24'sd100, 24'sd100, 24'sd0, 24'd33);
        end
        wait_idle();
    endtask

    // one frame that overflows the store; late entries compare but are dropped
    task automatic test_full_store();
        stall_pct = 40;
        gap_max = 4;
        set_all_regs(24'sd0, 24'sd0, 24'sd0, INV_RESET, INV_RESET, INV_RESET, 1'b0, 2'd0);
        for (int i = 0; i < 36; i++)
            send_loc(24'd900, jitter(24'sd5000, 500), jitter(-24'sd5000, 500),
                     24'($urandom), 24'($urandom));
        wait_idle();
    endtask

    task automatic test_default_tolerance();
        stall_pct = 30;
        gap_max = 6;
        run_frames(40, 600, 6);
        wait_idle();
    endtask

    task automatic test_offsets_3d();
        stall_pct = 70;
        gap_max = 10;
        set_all_regs(24'sd1000, -24'sd2000, 24'sd500, 41'd1717987, 41'd3435974,
                     41'd800000, 1'b1, 2'd1);
        run_frames(40, 700, 6);
        wait_idle();
    endtask

    task automatic test_zero_tolerance_weight();
        stall_pct = 0;
        gap_max = 2;
        set_all_regs(24'($urandom), 24'($urandom), 24'($urandom), '0, '0, '0, 1'b1, 2'd2);
        run_frames(40, 3000, 4);
        wait_idle();
    endtask

    task automatic test_extreme_offsets();
        stall_pct = 50;
        gap_max = 6;
        set_all_regs(-24'sd8388608, 24'sd8388607, -24'sd8388608, ONE_FX, ONE_FX, ONE_FX,
                     1'b1, 2'd3);
        run_frames(40, 1, 6);
        wait_idle();
    endtask

    task automatic test_mixed_2d();
        stall_pct = 20;
        gap_max = 3;
        set_all_regs(24'sd8388607, -24'sd300, 24'sd77, 41'd17179869, ONE_FX, 41'd1,
                     1'b0, 2'd2);
        run_frames(40, 40, 8);
        wait_idle();
    endtask

    initial begin
        off_x = 0; off_y = 0; off_z = 0;
        inv_x = INV_RESET; inv_y = INV_RESET; inv_z = INV_RESET;
        use_z_r = 1'b0;
        mode_r = 2'd0;
        held_n = 0;
        held_fr = '0;
        pairs_total = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_store();
        test_default_tolerance();
        test_offsets_3d();
        test_zero_tolerance_weight();
        test_extreme_offsets();
        test_mixed_2d();

        $display("covered %0d localizations and %0d pairs over six register settings",
                 locs_sent, pairs_seen);
        $display("including a full store, frame jumps both ways and all pairing modes");
        if (errors == 0 && expected_pairs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d pairs missing", errors, expected_pairs.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/smpm_pkg.sv
src/smpm_ctrl.sv
src/smpm_dp.sv
src/same_frame_pair_matcher.sv
tb/same_frame_pair_matcher_tb.sv
